>>> sv/queue_with_insert_at_position_core_defines.svh
// ----------------------------------------------------------------------------
// queue_with_insert_at_position_core_defines
// Assertion macros shared by the queue RTL files.
// ----------------------------------------------------------------------------
`ifndef QUEUE_WITH_INSERT_AT_POSITION_CORE_DEFINES_SVH
`define QUEUE_WITH_INSERT_AT_POSITION_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// check on every clock edge outside reset
`define QWIP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("qwip assertion failed");

// check on every clock edge, reset included
`define QWIP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error("qwip assertion failed");

`else

`define QWIP_ASSERT(lbl, prop)
`define QWIP_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> sv/qwip_pkg.sv
// ----------------------------------------------------------------------------
// qwip_pkg
// Widths, command and status codes and shared types of the queue core.
// ----------------------------------------------------------------------------
package qwip_pkg;

  // field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OCC_W    = 5;

  // default number of slots
  localparam int unsigned DEPTH_DEFAULT = 16;

  // command codes
  localparam logic [OP_W-1:0] OP_ENQ = 2'd0;
  localparam logic [OP_W-1:0] OP_DEQ = 2'd1;
  localparam logic [OP_W-1:0] OP_INS = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath command
  typedef struct packed {
    logic load;
  } ctrl_cmd_t;

endpackage

>>> sv/qwip_cmd_if.sv
// ----------------------------------------------------------------------------
// qwip_cmd_if
// Command channel: valid/ready handshake with op, value and position.
// ----------------------------------------------------------------------------
interface qwip_cmd_if;
  import qwip_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [OP_W-1:0]            op;
  logic signed [VALUE_W-1:0]  value;
  logic [POS_W-1:0]           position;

  modport source (output valid, op, value, position, input ready);
  modport sink   (input valid, op, value, position, output ready);

endinterface

>>> sv/qwip_rsp_if.sv
// ----------------------------------------------------------------------------
// qwip_rsp_if
// Response channel: valid/ready handshake with the result of one command.
// ----------------------------------------------------------------------------
interface qwip_rsp_if;
  import qwip_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [VALUE_W-1:0]  out_value;
  logic [STATUS_W-1:0]        status;
  logic [OCC_W-1:0]           occupancy;
  logic                       is_empty;

  modport source (output valid, out_value, status, occupancy, is_empty, input ready);
  modport sink   (input valid, out_value, status, occupancy, is_empty, output ready);

endinterface

>>> sv/qwip_ctrl.sv
// ----------------------------------------------------------------------------
// qwip_ctrl
// Handshake controller: takes a command beat when the response register is
// free or being drained, and tracks whether a response beat is pending.
// ----------------------------------------------------------------------------
`include "queue_with_insert_at_position_core_defines.svh"

module qwip_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output qwip_pkg::ctrl_cmd_t cmd_o
);
  import qwip_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_HOLD
  } state_e;

  state_e state_q, state_d;

  // ready while no response waits or the waiting one leaves now
  assign in_ready_o  = (state_q == S_IDLE) || out_ready_i;
  assign cmd_o.load  = in_valid_i && in_ready_o;
  assign out_valid_o = (state_q == S_HOLD);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.load) state_d = S_HOLD;
      end
      S_HOLD: begin
        if (cmd_o.load)       state_d = S_HOLD;
        else if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `QWIP_ASSERT(a_load_gives_beat, cmd_o.load |=> out_valid_o)
  `QWIP_ASSERT(a_idle_is_ready, !out_valid_o |-> in_ready_o)
  `QWIP_ASSERT_ALWAYS(a_reset_idle, !rst_ni |=> state_q == S_IDLE)

endmodule

>>> sv/qwip_dp.sv
// ----------------------------------------------------------------------------
// qwip_dp
// Queue datapath: shift register of slots with the head in slot zero, the
// fill count and the response register. Every slot picks its next value in
// parallel: hold, take the new value, shift toward the tail or the head.
// ----------------------------------------------------------------------------
`include "queue_with_insert_at_position_core_defines.svh"

module qwip_dp #(
  parameter int unsigned DEPTH = qwip_pkg::DEPTH_DEFAULT
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  qwip_pkg::ctrl_cmd_t                cmd_i,
  input  logic [qwip_pkg::OP_W-1:0]          op_i,
  input  logic signed [qwip_pkg::VALUE_W-1:0] value_i,
  input  logic [qwip_pkg::POS_W-1:0]         position_i,
  output logic signed [qwip_pkg::VALUE_W-1:0] out_value_o,
  output logic [qwip_pkg::STATUS_W-1:0]      status_o,
  output logic [qwip_pkg::OCC_W-1:0]         occupancy_o,
  output logic                               is_empty_o
);
  import qwip_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned WW = (CW > POS_W) ? CW : POS_W;

  logic signed [VALUE_W-1:0] slot_q [DEPTH];
  logic signed [VALUE_W-1:0] slot_d [DEPTH];
  logic [CW-1:0]             count_q, count_d;

  logic [WW-1:0]             cnt_w, pos_w, cut_w, ins_idx;
  logic                      is_full, is_zero;
  logic                      ins_en, deq_en;
  logic signed [VALUE_W-1:0] res_value;
  logic [STATUS_W-1:0]       res_status;
  logic [WW-1:0]             occ_w;

  logic signed [VALUE_W-1:0] out_value_q;
  logic [STATUS_W-1:0]       status_q;
  logic [OCC_W-1:0]          occ_q;
  logic                      empty_q;

  assign is_full = (count_q == CW'(DEPTH));
  assign is_zero = (count_q == '0);
  assign cnt_w   = WW'(count_q);
  assign pos_w   = WW'(position_i);

  // cut-in index: position clamped to one below, to the count above
  always_comb begin
    cut_w = (pos_w == '0) ? WW'(1) : pos_w;
    if (cut_w > cnt_w) cut_w = cnt_w;
  end

  // command decode
  always_comb begin
    ins_en     = 1'b0;
    deq_en     = 1'b0;
    ins_idx    = cnt_w;
    res_value  = '0;
    res_status = ST_OK;
    count_d    = count_q;
    unique case (op_i)
      OP_ENQ, OP_INS: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          ins_en  = 1'b1;
          ins_idx = (op_i == OP_INS) ? cut_w : cnt_w;
          count_d = count_q + CW'(1);
        end
      end
      OP_DEQ: begin
        if (is_zero) begin
          res_status = ST_EMPTY;
        end else begin
          deq_en    = 1'b1;
          res_value = slot_q[0];
          count_d   = count_q - CW'(1);
        end
      end
      default: ;
    endcase
  end

  // per-slot next value
  for (genvar i = 0; i < DEPTH; i++) begin : g_slot
    always_comb begin
      slot_d[i] = slot_q[i];
      if (ins_en) begin
        if (WW'(i) == ins_idx) begin
          slot_d[i] = value_i;
        end else if (WW'(i) > ins_idx) begin
          if (i > 0) slot_d[i] = slot_q[(i > 0) ? i - 1 : 0];
        end
      end else if (deq_en) begin
        if (i < DEPTH - 1) slot_d[i] = slot_q[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    // slot storage, no reset
    always_ff @(posedge clk_i) begin
      if (cmd_i.load) begin
        slot_q[i] <= slot_d[i];
      end
    end
  end

  // fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cmd_i.load) begin
      count_q <= count_d;
    end
  end

  // response register
  assign occ_w = WW'(count_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_value_q <= res_value;
      status_q    <= res_status;
      occ_q       <= occ_w[OCC_W-1:0];
      empty_q     <= (count_d == '0);
    end
  end

  assign out_value_o = out_value_q;
  assign status_o    = status_q;
  assign occupancy_o = occ_q;
  assign is_empty_o  = empty_q;

  `QWIP_ASSERT(a_count_bound, count_q <= CW'(DEPTH))
  `QWIP_ASSERT(a_full_only_when_full, cmd_i.load && !is_full |=> status_o != ST_FULL)
  `QWIP_ASSERT(a_deq_shrinks,
    cmd_i.load && op_i == OP_DEQ && !is_zero |=> count_q == $past(count_q) - CW'(1))

endmodule

>>> sv/queue_with_insert_at_position_core.sv
// ----------------------------------------------------------------------------
// queue_with_insert_at_position_core
// Bounded FIFO of signed 32-bit values with enqueue, dequeue and cut-in
// insert at a clamped position; one response beat per command beat.
//
//   channel  dir  handshake      payload
//   cmd_i    in   valid/ready    op, value, position
//   rsp_o    out  valid/ready    out_value, status, occupancy, is_empty
//
// On a command beat the slot shift register updates every slot in
// parallel, and the response lands in an output register the next cycle.
// A new command beat is taken in the cycle its response register empties,
// so back-to-back commands run at one per cycle while rsp_o.ready is high.
// A stall on rsp_o holds the response and blocks cmd_i until it drains.
// Reset clears the fill count and the controller; slots need no clearing.
// ----------------------------------------------------------------------------
module queue_with_insert_at_position_core #(
  parameter int unsigned DEPTH = qwip_pkg::DEPTH_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  qwip_cmd_if.sink   cmd_i,
  qwip_rsp_if.source rsp_o
);
  import qwip_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  logic      in_ready;
  logic      out_valid;

  // handshake controller
  qwip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (rsp_o.ready),
    .cmd_o       (ctrl_cmd)
  );

  assign cmd_i.ready = in_ready;
  assign rsp_o.valid = out_valid;

  // queue datapath
  qwip_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .op_i        (cmd_i.op),
    .value_i     (cmd_i.value),
    .position_i  (cmd_i.position),
    .out_value_o (rsp_o.out_value),
    .status_o    (rsp_o.status),
    .occupancy_o (rsp_o.occupancy),
    .is_empty_o  (rsp_o.is_empty)
  );

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the cut-in queue core. A shadow queue predicts
// the response to every accepted command beat. A clocked driver and monitor
// exercise the core under random idling and stalls on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import qwip_pkg::*;

  localparam int unsigned QDEPTH = DEPTH_DEFAULT;

  // unused opcode, must leave the queue untouched
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;

  localparam int unsigned RANDOM_CMDS = 450;
  localparam int unsigned LONG_HOLD   = 80;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    logic                      drain_first;
  } cmd_beat_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] out_value;
    logic [STATUS_W-1:0]       status;
    logic [OCC_W-1:0]          occupancy;
    logic                      is_empty;
  } rsp_beat_t;

  logic clk_i;
  logic rst_ni;

  qwip_cmd_if cmd_if ();
  qwip_rsp_if rsp_if ();

  queue_with_insert_at_position_core #(
    .DEPTH(QDEPTH)
  ) u_top (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cmd_i (cmd_if),
    .rsp_o (rsp_if)
  );

  // shadow of the stored values, head at index 0
  logic signed [VALUE_W-1:0] shadow_slots[$];
  cmd_beat_t                 pending_cmds[$];
  rsp_beat_t                 rsp_due[$];

  int unsigned errors;
  int unsigned cmds_taken;
  int unsigned rsps_seen;
  int unsigned op_hits[4];
  int unsigned full_drops;
  int unsigned empty_deqs;
  int unsigned peak_occ;
  int unsigned long_holds;

  bit          cmd_taken;
  int unsigned send_gap;
  int unsigned send_calm;
  int unsigned hold_cnt;
  int unsigned recv_calm;
  int unsigned next_long_hold;
  cmd_beat_t   next_beat;

  // apply one command to the shadow queue and return its response
  function automatic rsp_beat_t apply_to_shadow(logic [OP_W-1:0] op,
                                                logic signed [VALUE_W-1:0] value,
                                                logic [POS_W-1:0] position);
    rsp_beat_t   r;
    int unsigned slot;
    r        = '0;
    r.status = ST_OK;
    case (op)
      OP_ENQ, OP_INS: begin
        if (shadow_slots.size() >= QDEPTH) begin
          r.status = ST_FULL;
        end else if (op == OP_ENQ) begin
          shadow_slots.push_back(value);
        end else begin
          // position zero goes behind the head, beyond the tail appends
          slot = (position < 1) ? 1 : position;
          if (slot >= shadow_slots.size()) begin
            shadow_slots.push_back(value);
          end else begin
            shadow_slots.insert(slot, value);
          end
        end
      end
      OP_DEQ: begin
        if (shadow_slots.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.out_value = shadow_slots.pop_front();
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(shadow_slots.size());
    r.is_empty  = (shadow_slots.size() == 0);
    return r;
  endfunction

  // idle length: mostly none or short, a few long, now and then a calm run
  function automatic int unsigned pick_gap(inout int unsigned calm);
    int unsigned r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) begin
      calm = $urandom_range(60, 20);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // random command; fill_bias leans toward growing the queue
  function automatic cmd_beat_t rand_beat(bit fill_bias);
    cmd_beat_t   b;
    int unsigned r;
    b = '0;
    r = $urandom_range(99);
    if (r < 3) begin
      b.op = OP_NOP;
    end else if (r < (fill_bias ? 70 : 35)) begin
      b.op = $urandom_range(1) ? OP_ENQ : OP_INS;
    end else begin
      b.op = OP_DEQ;
    end
    case ($urandom_range(3))
      0: b.value = $signed($urandom_range(16)) - 8;
      1: begin
        case ($urandom_range(3))
          0: b.value = 32'sh7fffffff;
          1: b.value = 32'sh80000000;
          2: b.value = 32'sh0;
          default: b.value = -32'sd1;
        endcase
      end
      default: b.value = $urandom;
    endcase
    b.position = POS_W'(($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(17));
    return b;
  endfunction

  task automatic add_cmd(logic [OP_W-1:0] op, logic signed [VALUE_W-1:0] value,
                         logic [POS_W-1:0] position);
    cmd_beat_t b;
    b.op          = op;
    b.value       = value;
    b.position    = position;
    b.drain_first = 1'b0;
    pending_cmds.push_back(b);
  endtask

  task automatic report_field(string field, longint exp_v, longint act_v);
    errors++;
    $display("%0t ns: response %0d field %s expected %0d actual %0d",
             $time, rsps_seen, field, exp_v, act_v);
  endtask

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // command driver, changes at the falling edge
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      cmd_if.valid <= 1'b0;
    end else if (cmd_if.valid && !cmd_taken) begin
      // beat still offered, hold it
    end else if (send_gap > 0) begin
      cmd_if.valid <= 1'b0;
      send_gap--;
    end else if (pending_cmds.size() != 0 &&
                 (!pending_cmds[0].drain_first || rsp_due.size() == 0)) begin
      next_beat         = pending_cmds.pop_front();
      cmd_if.op       <= next_beat.op;
      cmd_if.value    <= next_beat.value;
      cmd_if.position <= next_beat.position;
      cmd_if.valid    <= 1'b1;
      send_gap          = pick_gap(send_calm);
    end else begin
      cmd_if.valid <= 1'b0;
    end
  end

  // response ready, with a long hold-off now and then
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      rsp_if.ready <= 1'b0;
      hold_cnt--;
    end else if (rsps_seen >= next_long_hold) begin
      rsp_if.ready   <= 1'b0;
      hold_cnt        = LONG_HOLD - 1;
      next_long_hold += 210;
      long_holds++;
    end else begin
      hold_cnt = pick_gap(recv_calm);
      if (hold_cnt > 0) begin
        rsp_if.ready <= 1'b0;
        hold_cnt--;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // monitor: predict on each command beat, check each response beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cmd_taken = cmd_if.valid && cmd_if.ready;
      if (cmd_taken) begin
        rsp_due.push_back(apply_to_shadow(cmd_if.op, cmd_if.value, cmd_if.position));
        cmds_taken++;
        op_hits[cmd_if.op]++;
        if (shadow_slots.size() > peak_occ) peak_occ = shadow_slots.size();
        if (rsp_due[$].status == ST_FULL) full_drops++;
        if (rsp_due[$].status == ST_EMPTY) empty_deqs++;
      end
      if (rsp_if.valid && rsp_if.ready) begin
        if (rsp_due.size() == 0) begin
          errors++;
          $display("%0t ns: response beat with nothing outstanding, got value %0d status %0d",
                   $time, rsp_if.out_value, rsp_if.status);
        end else begin
          rsp_beat_t want;
          want = rsp_due.pop_front();
          if (rsp_if.out_value !== want.out_value)
            report_field("out_value", want.out_value, rsp_if.out_value);
          if (rsp_if.status !== want.status)
            report_field("status", want.status, rsp_if.status);
          if (rsp_if.occupancy !== want.occupancy)
            report_field("occupancy", want.occupancy, rsp_if.occupancy);
          if (rsp_if.is_empty !== want.is_empty)
            report_field("is_empty", want.is_empty, rsp_if.is_empty);
        end
        rsps_seen++;
      end
    end
  end

  // stimulus, reset and end of run
  initial begin
    cmd_beat_t b;
    rst_ni          = 1'b0;
    cmd_if.valid    = 1'b0;
    cmd_if.op       = OP_ENQ;
    cmd_if.value    = '0;
    cmd_if.position = '0;
    rsp_if.ready    = 1'b0;
    errors          = 0;
    cmds_taken      = 0;
    rsps_seen       = 0;
    full_drops      = 0;
    empty_deqs      = 0;
    peak_occ        = 0;
    long_holds      = 0;
    cmd_taken       = 1'b0;
    send_gap        = 0;
    send_calm       = 0;
    hold_cnt        = 0;
    recv_calm       = 0;
    next_long_hold  = 120;
    foreach (op_hits[i]) op_hits[i] = 0;

    // directed: empty queue corner cases
    add_cmd(OP_DEQ, 32'sd0, 5'd0);
    add_cmd(OP_NOP, 32'sd7, 5'd3);
    add_cmd(OP_INS, 32'sd11, 5'd17);
    add_cmd(OP_ENQ, 32'sh7fffffff, 5'd0);
    add_cmd(OP_ENQ, 32'sh80000000, 5'd31);
    // insert at zero lands behind the head, then plain index one
    add_cmd(OP_INS, -32'sd5, 5'd0);
    add_cmd(OP_INS, 32'sd22, 5'd1);
    // beyond the tail and exactly at the tail both append
    add_cmd(OP_INS, 32'sd33, 5'd31);
    add_cmd(OP_INS, 32'sd44, 5'd6);
    add_cmd(OP_INS, 32'sd55, 5'd3);
    add_cmd(OP_DEQ, 32'sd0, 5'd0);
    // fill up, then hit the full queue with enqueue, insert and the unused opcode
    for (int k = 0; k < 9; k++) add_cmd(OP_ENQ, 32'sha5a50000 + k, 5'd0);
    add_cmd(OP_ENQ, -32'sd1, 5'd0);
    add_cmd(OP_INS, 32'sd99, 5'd0);
    add_cmd(OP_NOP, 32'sd0, 5'd0);

    // random: segments alternate between draining and filling
    for (int i = 0; i < RANDOM_CMDS; i++) begin
      b = rand_beat(((i / 25) % 2) == 1);
      b.drain_first = (i == 0) || (i == 250);
      pending_cmds.push_back(b);
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    do @(posedge clk_i);
    while (pending_cmds.size() != 0 || cmd_if.valid || rsp_due.size() != 0);
    repeat (10) @(posedge clk_i);

    $display("covered %0d commands (enq %0d, deq %0d, insert %0d, unused op %0d), %0d responses",
             cmds_taken, op_hits[OP_ENQ], op_hits[OP_DEQ], op_hits[OP_INS],
             op_hits[OP_NOP], rsps_seen);
    $display("full drops %0d, empty dequeues %0d, peak fill %0d, long stalls %0d, mismatches %0d",
             full_drops, empty_deqs, peak_occ, long_holds, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
